FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hdl/rdw_pkg.sv
// ----------------------------------------------------------------------------
// rdw_pkg
// Shared types and constants of the recent distinct value window
// ----------------------------------------------------------------------------
package rdw_pkg;

	// command codes carried on s_tuser
	localparam logic CMD_OFFER = 1'b0;
	localparam logic CMD_DUMP  = 1'b1;

	localparam int VALUE_W = 32;
	localparam int SIZE_W  = 6;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 3;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic offer_do;
		logic dump_emit;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_dump;
		logic out_free;
		logic dump_last;
	} dp_status_t;

endpackage

FILE: hdl/rdw_ctrl.sv
// ----------------------------------------------------------------------------
// rdw_ctrl
// Request sequencer: captures a request, then runs the offer or the dump walk
// ----------------------------------------------------------------------------
module rdw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  rdw_pkg::dp_status_t status,
	output rdw_pkg::ctrl_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		cmd.capture   = 1'b0;
		cmd.offer_do  = 1'b0;
		cmd.dump_emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.out_free) begin
					if (status.is_dump) begin
						cmd.dump_emit = 1'b1;
						if (status.dump_last) begin
							state_d = ST_IDLE;
						end
					end else begin
						cmd.offer_do = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/rdw_datapath.sv
// ----------------------------------------------------------------------------
// rdw_datapath
// Entry ring with per-entry valid bits, parallel match, dump walk and
// the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdw_datapath #(
	parameter int DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [rdw_pkg::SIZE_W-1:0]          cfg_data,
	input  logic [rdw_pkg::VALUE_W-1:0]         s_tdata,
	input  logic                                s_tuser,
	input  rdw_pkg::ctrl_cmd_t                  cmd,
	output rdw_pkg::dp_status_t                 status,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [rdw_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [rdw_pkg::OUT_USER_W-1:0]      m_tuser,
	output logic                                m_tlast
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = 7;

	logic [rdw_pkg::VALUE_W-1:0] entries_q [DEPTH];
	logic [DEPTH-1:0]            valid_q;
	logic [DEPTH-1:0]            valid_d;
	logic [PW-1:0]               oldest_q;
	logic [PW-1:0]               tail_q;
	logic [CW-1:0]               count_q;
	logic [rdw_pkg::SIZE_W-1:0]  wsize_q;

	logic [rdw_pkg::VALUE_W-1:0] value_q;
	logic                        dump_q;
	logic [PW-1:0]               dptr_q;
	logic [CW-1:0]               remain_q;

	logic                        out_valid_q;
	logic                        acc_q;
	logic                        ev_q;
	logic [rdw_pkg::VALUE_W-1:0] evv_q;
	logic                        dv_q;
	logic [rdw_pkg::VALUE_W-1:0] dval_q;
	logic [rdw_pkg::SIZE_W-1:0]  wcnt_q;
	logic                        last_q;

	logic [DEPTH-1:0]            match;
	logic                        hit;
	logic [LW-1:0]               lim;
	logic                        full;
	logic                        evict;
	logic [PW-1:0]               rd_addr;
	logic [rdw_pkg::VALUE_W-1:0] rd_data;
	logic [CW-1:0]               count_next;
	logic [CW+rdw_pkg::SIZE_W-1:0] count_ext;
	logic [CW+rdw_pkg::SIZE_W-1:0] count_cur_ext;
	logic                        out_free;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
		return r;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
		return r;
	endfunction

	// parallel match against held entries
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = valid_q[i] && (entries_q[i] == value_q);
		end
	end
	assign hit = |match;

	// effective window limit: zero acts as one, saturate at DEPTH
	always_comb begin
		lim = LW'(wsize_q);
		if (lim == '0) begin
			lim = LW'(1);
		end
		if (lim > LW'(DEPTH)) begin
			lim = LW'(DEPTH);
		end
	end
	assign full  = LW'(count_q) >= lim;
	assign evict = !hit && full;

	// single read port: oldest entry on offers, walk pointer on dumps
	assign rd_addr = dump_q ? dptr_q : oldest_q;
	assign rd_data = entries_q[rd_addr];

	assign count_next    = (hit || evict) ? count_q : count_q + CW'(1);
	assign count_ext     = {{rdw_pkg::SIZE_W{1'b0}}, count_next};
	assign count_cur_ext = {{rdw_pkg::SIZE_W{1'b0}}, count_q};

	assign out_free = !out_valid_q || m_tready;

	assign status.is_dump   = dump_q;
	assign status.out_free  = out_free;
	assign status.dump_last = remain_q <= CW'(1);

	// valid bits: clear the evicted slot, then mark the written slot
	always_comb begin
		valid_d = valid_q;
		if (cmd.offer_do && !hit) begin
			if (evict) begin
				valid_d[oldest_q] = 1'b0;
			end
			valid_d[tail_q] = 1'b1;
		end
	end

	// ring control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			oldest_q <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			wsize_q  <= rdw_pkg::SIZE_W'(32);
			dump_q   <= rdw_pkg::CMD_OFFER;
			remain_q <= '0;
		end else begin
			valid_q <= valid_d;
			if (cfg_valid) begin
				wsize_q <= cfg_data;
			end
			if (cmd.capture) begin
				dump_q   <= s_tuser;
				remain_q <= count_q;
			end
			if (cmd.dump_emit && remain_q != '0) begin
				remain_q <= remain_q - CW'(1);
			end
			if (cmd.offer_do && !hit) begin
				if (evict) begin
					oldest_q <= ptr_inc(oldest_q);
				end
				tail_q  <= ptr_inc(tail_q);
				count_q <= count_next;
			end
		end
	end

	// entry storage and request payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			value_q <= s_tdata;
			dptr_q  <= ptr_dec(tail_q);
		end
		if (cmd.dump_emit) begin
			dptr_q <= ptr_dec(dptr_q);
		end
		if (cmd.offer_do && !hit) begin
			entries_q[tail_q] <= value_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.offer_do || cmd.dump_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.offer_do) begin
			acc_q  <= !hit;
			ev_q   <= evict;
			evv_q  <= evict ? rd_data : '0;
			dv_q   <= 1'b0;
			dval_q <= '0;
			wcnt_q <= count_ext[rdw_pkg::SIZE_W-1:0];
			last_q <= 1'b1;
		end else if (cmd.dump_emit) begin
			acc_q  <= 1'b0;
			ev_q   <= 1'b0;
			evv_q  <= '0;
			dv_q   <= remain_q != '0;
			dval_q <= (remain_q != '0) ? rd_data : '0;
			wcnt_q <= count_cur_ext[rdw_pkg::SIZE_W-1:0];
			last_q <= remain_q <= CW'(1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, wcnt_q, dval_q, evv_q};
	assign m_tuser  = {dv_q, ev_q, acc_q};
	assign m_tlast  = last_q;

	`ASSERT_ALWAYS(a_valid_matches_count, clk, arst_n,
		$countones(valid_q) == 32'(count_q), "valid bits disagree with held count")
	`ASSERT_ALWAYS(a_count_bounded, clk, arst_n,
		32'(count_q) <= DEPTH, "held count exceeds depth")
	`ASSERT_IMPLIES(a_evict_needs_accept, clk, arst_n,
		out_valid_q && ev_q, acc_q, "eviction reported without append")

endmodule

FILE: hdl/recent_distinct_window.sv
// ----------------------------------------------------------------------------
// recent_distinct_window
// First-in first-out window of the most recent distinct 32-bit values
// ----------------------------------------------------------------------------
// An offer request (s_tuser = 0) is captured first; the execute state then
// does the parallel compare against all DEPTH entries and the ring update.
// A dump request (s_tuser = 1) is captured and then walks the entries newest
// first through the single read port of the entry file, one result per cycle
// unless output back-pressure holds it; an empty window gives one result with
// dump_valid low. Output back-pressure also stalls an offer. The finished
// result sits in an output register, so the next request is taken while it
// waits. window_size may be written in any cycle while the block is idle; a
// value of zero acts as one and a value above DEPTH saturates to DEPTH. The
// window starts empty after reset with no clearing pass.
module recent_distinct_window #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// window_size register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value
	input  logic        s_tuser,  // command
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // evicted_value, dump_value, window_count
	output logic [2:0]  m_tuser,  // accepted, evicted, dump_valid
	output logic        m_tlast
);

	rdw_pkg::ctrl_cmd_t  cmd;
	rdw_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	rdw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// storage, match and output register
	rdw_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.status    (status),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the recent distinct value window
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and results come out on the master
// stream, with random gaps and stalls on both sides. A tracker class keeps
// its own copy of the window ring and of window_size. For every accepted
// request it predicts the results, and it checks each returned result field
// by field in arrival order. window_size is rewritten only with the block
// drained, over a range of sizes that includes zero, one, DEPTH and the
// largest code.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RING_DEPTH   = 32;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int PHASE_ITEMS  = 32;
	localparam int LONG_HOLD    = 300;

	// one expected result of the window
	typedef struct packed {
		bit        accepted;
		bit        evicted;
		bit [31:0] evicted_value;
		bit        dump_valid;
		bit [31:0] dump_value;
		bit [5:0]  window_count;
		bit        last;
	} window_result_t;

	// predicts the window contents and checks returned results in order
	class window_tracker;
		bit [31:0]      ring [RING_DEPTH];
		int unsigned    oldest;
		int unsigned    held;
		bit [5:0]       size_reg;
		window_result_t pending_results[$];
		int unsigned    mismatches;

		function new();
			oldest = 0;
			held = 0;
			size_reg = 6'd32;
			mismatches = 0;
		endfunction

		function void write_size(bit [5:0] size);
			size_reg = size;
		endfunction

		// zero acts as one, anything above the ring depth saturates
		function int unsigned size_limit();
			if (size_reg == 0)
				return 1;
			if (size_reg > RING_DEPTH)
				return RING_DEPTH;
			return 32'(size_reg);
		endfunction

		function void note_request(logic cmd, logic [31:0] value);
			window_result_t res;
			bit hit;
			int unsigned i;
			res = '0;
			res.last = 1'b1;
			if (cmd == rdw_pkg::CMD_OFFER) begin
				hit = 1'b0;
				for (i = 0; i < held; i++)
					if (ring[(oldest + i) % RING_DEPTH] == value)
						hit = 1'b1;
				// new value: drop the oldest when at the limit, then append
				if (!hit) begin
					if (held >= size_limit() && held > 0) begin
						res.evicted = 1'b1;
						res.evicted_value = ring[oldest];
						oldest = (oldest + 1) % RING_DEPTH;
						held--;
					end
					ring[(oldest + held) % RING_DEPTH] = value;
					held++;
					res.accepted = 1'b1;
				end
				res.window_count = 6'(held);
				pending_results.push_back(res);
			end else if (held == 0) begin
				pending_results.push_back(res);
			end else begin
				// dump walks newest to oldest
				for (i = 0; i < held; i++) begin
					res = '0;
					res.dump_valid = 1'b1;
					res.dump_value = ring[(oldest + held - 1 - i) % RING_DEPTH];
					res.window_count = 6'(held);
					res.last = (i + 1 == held);
					pending_results.push_back(res);
				end
			end
		endfunction

		function void compare_field(string name, logic [31:0] actual, bit [31:0] wanted);
			if (actual !== wanted) begin
				$error("%s mismatch: expected %0h, actual %0h", name, wanted, actual);
				mismatches++;
			end
		endfunction

		function void check_result(logic [71:0] data, logic [2:0] user, logic tlast);
			window_result_t exp;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: tdata %0h tuser %0h tlast %0b",
					data, user, tlast);
				mismatches++;
				return;
			end
			exp = pending_results.pop_front();
			compare_field("accepted", 32'(user[0]), 32'(exp.accepted));
			compare_field("evicted", 32'(user[1]), 32'(exp.evicted));
			compare_field("dump_valid", 32'(user[2]), 32'(exp.dump_valid));
			compare_field("evicted_value", data[31:0], exp.evicted_value);
			compare_field("dump_value", data[63:32], exp.dump_value);
			compare_field("window_count", 32'(data[69:64]), 32'(exp.window_count));
			compare_field("last", 32'(tlast), 32'(exp.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // value
	logic        s_tuser;   // command
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // evicted_value, dump_value, window_count
	logic [2:0]  m_tuser;   // accepted, evicted, dump_valid
	logic        m_tlast;

	window_tracker tracker = new();

	int unsigned cycle_count;
	int unsigned hold_requests;
	int unsigned holds_served;
	bit          no_gaps;
	bit [31:0]   value_pool [40];
	int unsigned pool_size;

	recent_distinct_window dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// monitor both streams at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	// result side back-pressure: segments of always ready, random, or stalled
	initial begin
		int unsigned hold_left;
		int unsigned seg_left;
		int unsigned seg_mode;
		m_tready = 1'b0;
		hold_left = 0;
		seg_left = 0;
		seg_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_mode = $urandom_range(0, 9);
					if (seg_mode == 9)
						seg_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
							: $urandom_range(1, 6);
					else
						seg_left = $urandom_range(5, 60);
				end
				seg_left--;
				if (seg_mode <= 3)
					m_tready <= 1'b1;
				else if (seg_mode <= 8)
					m_tready <= ($urandom_range(0, 3) != 0);
				else
					m_tready <= 1'b0;
			end
		end
	end

	// sender gap: mostly none or short, a few long
	function int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one request and hold it until taken; valid stays high afterwards
	task send_request(input logic cmd, input logic [31:0] value);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait until every predicted result has come back
	task wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// window_size write, only with the block drained
	task write_window_size(input logic [5:0] size);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= size;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_size(size);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer value: mostly from the phase pool so repeats and evictions occur
	function logic [31:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 8)
			return value_pool[$urandom_range(0, pool_size - 1)];
		return $urandom();
	endfunction

	task run_phase(input logic [5:0] size, input int unsigned phase);
		int unsigned lim;
		int unsigned i;
		write_window_size(size);
		lim = (size == 0) ? 1 : ((size > RING_DEPTH) ? RING_DEPTH : size);
		pool_size = $urandom_range(lim / 2 + 1, (lim + 8 > 40) ? 40 : lim + 8);
		for (i = 0; i < pool_size; i++) begin
			case ($urandom_range(0, 9))
				0: value_pool[i] = 32'h0000_0000 + i;
				1: value_pool[i] = 32'hFFFF_FFFF - i;
				default: value_pool[i] = $urandom();
			endcase
		end
		no_gaps = (phase % 3 == 0);
		// long receiver hold while the sender keeps pushing
		if (phase == 2) begin
			no_gaps = 1'b1;
			hold_requests++;
		end
		for (i = 0; i < PHASE_ITEMS; i++) begin
			// sender pause until all results are back
			if (phase == 4 && i == PHASE_ITEMS / 2)
				wait_drained();
			if ($urandom_range(0, 9) == 0)
				send_request(rdw_pkg::CMD_DUMP, $urandom());
			else
				send_request(rdw_pkg::CMD_OFFER, pick_value());
		end
		wait_drained();
	endtask

	initial begin
		logic [5:0] phase_sizes [9];
		int unsigned p;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tuser = rdw_pkg::CMD_OFFER;
		s_tdata = '0;
		cycle_count = 0;
		hold_requests = 0;
		holds_served = 0;
		no_gaps = 1'b0;
		pool_size = 1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// empty dump, extremes, a repeated value, a full listing
		send_request(rdw_pkg::CMD_DUMP, 32'hDEAD_BEEF);
		send_request(rdw_pkg::CMD_OFFER, 32'h0000_0000);
		send_request(rdw_pkg::CMD_OFFER, 32'hFFFF_FFFF);
		send_request(rdw_pkg::CMD_OFFER, 32'h0000_0000);
		send_request(rdw_pkg::CMD_OFFER, 32'h8000_0001);
		send_request(rdw_pkg::CMD_DUMP, 32'h0000_0000);
		wait_drained();

		// window shrunk below the held count: evict one per new value
		write_window_size(6'd1);
		send_request(rdw_pkg::CMD_OFFER, 32'h1234_5678);
		send_request(rdw_pkg::CMD_OFFER, 32'hFFFF_FFFF);
		send_request(rdw_pkg::CMD_OFFER, 32'hA5A5_A5A5);
		send_request(rdw_pkg::CMD_DUMP, 32'hFFFF_FFFF);
		wait_drained();

		// size zero behaves as one
		write_window_size(6'd0);
		send_request(rdw_pkg::CMD_OFFER, 32'h0000_0007);
		send_request(rdw_pkg::CMD_OFFER, 32'h0000_0009);
		send_request(rdw_pkg::CMD_DUMP, 32'h0000_0000);
		wait_drained();

		// largest code saturates to the ring depth
		write_window_size(6'd63);
		send_request(rdw_pkg::CMD_OFFER, 32'h5A5A_5A5A);
		send_request(rdw_pkg::CMD_OFFER, 32'h7FFF_FFFF);
		send_request(rdw_pkg::CMD_OFFER, 32'h0000_0009);
		send_request(rdw_pkg::CMD_DUMP, 32'h0000_0000);
		wait_drained();

		// random phases over a spread of window sizes
		phase_sizes[0] = 6'd32;
		phase_sizes[1] = 6'd2;
		phase_sizes[2] = 6'd63;
		phase_sizes[3] = 6'd5;
		phase_sizes[4] = 6'd0;
		phase_sizes[5] = 6'd33;
		phase_sizes[6] = 6'd1;
		phase_sizes[7] = 6'd17;
		phase_sizes[8] = 6'($urandom_range(0, 63));
		for (p = 0; p < 9; p++)
			run_phase(phase_sizes[p], p);

		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			if (tracker.pending_results.size() != 0)
				$error("%0d expected results never arrived", tracker.pending_results.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
